>>> hdl/tss_pkg.sv
// task slot scheduler package: request types, codes and controller/datapath links
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    localparam int SLOT_COUNT_DEF   = 32;
    localparam int VECTOR_COUNT_DEF = 128;
    localparam int VEC_W            = 7;
    localparam int WOKEN_CNT_W      = 7;
    localparam logic [VEC_W-1:0] PREEMPT_RESET = 7'd40;
    localparam logic [WOKEN_CNT_W-1:0] WOKEN_MAX = 7'd63;

    typedef enum logic [2:0] {
        CMD_CREATE   = 3'd0,
        CMD_ARM      = 3'd1,
        CMD_WAIT     = 3'd2,
        CMD_INTR     = 3'd3,
        CMD_DISPATCH = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_RUN     = 2'd1,
        ST_RUNNING = 2'd2,
        ST_WAIT    = 2'd3
    } t_slot_st;

    typedef enum logic [1:0] {
        STS_OK            = 2'd0,
        STS_NO_FREE       = 2'd1,
        STS_NONE_RUNNABLE = 2'd2,
        STS_NO_ACTIVE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SCAN_FIND_EMPTY = 2'd0,
        SCAN_FIND_RUN   = 2'd1,
        SCAN_WAKE       = 2'd2
    } t_scan_mode;

    typedef struct packed {
        logic [2:0]       command;
        logic [VEC_W-1:0] vector;
    } t_in_req;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] slot_index;
        logic       preempted;
        logic [5:0] woken_count;
    } t_out_req;

    typedef struct packed {
        logic       capture;
        logic       init;
        t_status    init_status;
        logic       set_pre;
        logic       demote;
        logic       park;
        logic       mark_dispatched;
        logic       scan_start;
        logic       scan_from_ptr;
        logic       scan_run;
        t_scan_mode mode;
        logic       mask_read;
        logic       mask_write;
        logic       load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic       active_valid;
        logic       ever_dispatched;
        logic       vec_ok;
        logic       preempt_hit;
        logic       hit;
        logic       scan_done;
        logic       out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hdl/tss_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/tss_ctrl.sv
// task slot scheduler controller: sequences each request through decode, a scan or a mask update, and reply
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

module tss_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tss_pkg::t_dp_stat  i_stat,
    output tss_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ARM_RD,
        S_ARM_WR,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    tss_pkg::t_scan_mode r_mode, n_mode;
    tss_pkg::t_dp_cmd    cmd;

    always_comb begin
        n_state         = r_state;
        n_mode          = r_mode;
        cmd             = '0;
        cmd.init_status = tss_pkg::STS_OK;
        cmd.mode        = r_mode;
        unique case (r_state)
            S_IDLE: begin
                cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.init = 1'b1;
                n_state  = S_DONE;
                unique case (i_stat.cmd)
                    tss_pkg::CMD_CREATE: begin
                        cmd.init_status = tss_pkg::STS_NO_FREE;
                        cmd.scan_start  = 1'b1;
                        n_mode          = tss_pkg::SCAN_FIND_EMPTY;
                        n_state         = S_SCAN;
                    end
                    tss_pkg::CMD_ARM: begin
                        if (!i_stat.active_valid) begin
                            cmd.init_status = tss_pkg::STS_NO_ACTIVE;
                        end else if (i_stat.vec_ok) begin
                            n_state = S_ARM_RD;
                        end
                    end
                    tss_pkg::CMD_WAIT: begin
                        if (!i_stat.active_valid) begin
                            cmd.init_status = tss_pkg::STS_NO_ACTIVE;
                        end else begin
                            cmd.park = 1'b1;
                        end
                    end
                    tss_pkg::CMD_INTR: begin
                        if (i_stat.ever_dispatched) begin
                            cmd.demote     = i_stat.preempt_hit;
                            cmd.set_pre    = i_stat.preempt_hit;
                            cmd.scan_start = 1'b1;
                            n_mode         = tss_pkg::SCAN_WAKE;
                            n_state        = S_SCAN;
                        end
                    end
                    tss_pkg::CMD_DISPATCH: begin
                        cmd.init_status     = tss_pkg::STS_NONE_RUNNABLE;
                        cmd.demote          = i_stat.active_valid;
                        cmd.mark_dispatched = 1'b1;
                        cmd.scan_start      = 1'b1;
                        cmd.scan_from_ptr   = 1'b1;
                        n_mode              = tss_pkg::SCAN_FIND_RUN;
                        n_state             = S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (i_stat.hit || i_stat.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_ARM_RD: begin
                cmd.mask_read = 1'b1;
                n_state       = S_ARM_WR;
            end
            S_ARM_WR: begin
                cmd.mask_write = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                cmd.load_out = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= tss_pkg::SCAN_FIND_EMPTY;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

>>> hdl/tss_datapath.sv
// task slot scheduler datapath: slot state and mask memories, scan engine, result register
// depends on tss_pkg and tss_ram
`timescale 1ns / 1ps
`default_nettype none

module tss_datapath #(
    parameter int SLOT_COUNT   = tss_pkg::SLOT_COUNT_DEF,
    parameter int VECTOR_COUNT = tss_pkg::VECTOR_COUNT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire tss_pkg::t_in_req          i_in_data,
    input  wire logic                      i_cfg_valid,
    input  wire logic [tss_pkg::VEC_W-1:0] i_cfg_data,
    input  wire logic                      i_out_stall,
    output logic                           o_out_valid,
    output tss_pkg::t_out_req              o_out_data,
    input  wire tss_pkg::t_dp_cmd          i_cmd,
    output tss_pkg::t_dp_stat              o_stat
);

    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int LEFT_W    = $clog2(SLOT_COUNT + 1);
    localparam int VI_W      = $clog2(VECTOR_COUNT);
    localparam int IDX_EXT_W = (SLOT_W > 5) ? SLOT_W : 5;

    // request and configuration
    logic [2:0]                r_cmd;
    logic [tss_pkg::VEC_W-1:0] r_vec;
    logic [tss_pkg::VEC_W-1:0] r_preempt;

    // scheduler state
    logic [SLOT_W-1:0]     r_active;
    logic                  r_active_valid;
    logic                  r_ever;
    logic [SLOT_W-1:0]     r_scan_ptr;
    logic [SLOT_COUNT-1:0] r_vbits;

    // scan engine
    logic [SLOT_W-1:0] r_rd_addr;
    logic [LEFT_W-1:0] r_left;
    logic              r_chk_vld;
    logic [SLOT_W-1:0] r_chk_addr;
    logic              r_chk_vbit;

    // result
    tss_pkg::t_status             r_status;
    logic [SLOT_W-1:0]            r_idx;
    logic                         r_pre;
    logic [tss_pkg::WOKEN_CNT_W-1:0] r_woken;
    logic                         r_out_valid;
    tss_pkg::t_out_req            r_out;

    logic [1:0]              st_rdata;
    logic                    st_we;
    logic [SLOT_W-1:0]       st_waddr;
    logic [1:0]              st_wdata;
    logic [VECTOR_COUNT-1:0] mask_rdata;
    logic                    mask_we;
    logic [SLOT_W-1:0]       mask_waddr;
    logic [VECTOR_COUNT-1:0] mask_wdata;
    logic [SLOT_W-1:0]       mask_raddr;

    tss_pkg::t_slot_st       st_eff;
    logic                    vec_ok;
    logic [VI_W-1:0]         vi;
    logic [VECTOR_COUNT-1:0] bit_sel;
    logic                    scan_active;
    logic                    find_empty_hit;
    logic                    find_run_hit;
    logic                    wake_hit;
    logic                    left_nz;
    logic [SLOT_W-1:0]       rd_next;
    logic [SLOT_W-1:0]       chk_next;
    logic [IDX_EXT_W-1:0]    idx_ext;
    logic [5:0]              woken_sat;

    tss_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (st_rdata)
    );

    tss_ram #(.WIDTH(VECTOR_COUNT), .DEPTH(SLOT_COUNT)) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (mask_we),
        .i_waddr (mask_waddr),
        .i_wdata (mask_wdata),
        .i_raddr (mask_raddr),
        .o_rdata (mask_rdata)
    );

    assign st_eff  = r_chk_vbit ? tss_pkg::t_slot_st'(st_rdata) : tss_pkg::ST_EMPTY;
    assign vec_ok  = ({1'b0, r_vec} < 8'(VECTOR_COUNT));
    assign vi      = r_vec[VI_W-1:0];
    assign bit_sel = {{(VECTOR_COUNT-1){1'b0}}, 1'b1} << vi;
    assign left_nz = (r_left != '0);

    assign rd_next  = (r_rd_addr == SLOT_W'(SLOT_COUNT - 1)) ? '0 : r_rd_addr + 1'b1;
    assign chk_next = (r_chk_addr == SLOT_W'(SLOT_COUNT - 1)) ? '0 : r_chk_addr + 1'b1;

    assign scan_active    = i_cmd.scan_run && r_chk_vld;
    assign find_empty_hit = scan_active && (i_cmd.mode == tss_pkg::SCAN_FIND_EMPTY)
                            && (st_eff == tss_pkg::ST_EMPTY);
    assign find_run_hit   = scan_active && (i_cmd.mode == tss_pkg::SCAN_FIND_RUN)
                            && (st_eff == tss_pkg::ST_RUN);
    assign wake_hit       = scan_active && (i_cmd.mode == tss_pkg::SCAN_WAKE) && vec_ok
                            && (st_eff == tss_pkg::ST_WAIT) && mask_rdata[vi];

    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_active;
        st_wdata = tss_pkg::ST_RUN;
        if (i_cmd.demote) begin
            st_we = 1'b1;
        end else if (i_cmd.park) begin
            st_we    = 1'b1;
            st_wdata = tss_pkg::ST_WAIT;
        end else if (find_empty_hit || wake_hit) begin
            st_we    = 1'b1;
            st_waddr = r_chk_addr;
        end else if (find_run_hit) begin
            st_we    = 1'b1;
            st_waddr = r_chk_addr;
            st_wdata = tss_pkg::ST_RUNNING;
        end
    end

    assign mask_we    = find_empty_hit || i_cmd.mask_write;
    assign mask_waddr = find_empty_hit ? r_chk_addr : r_active;
    assign mask_wdata = find_empty_hit ? '0 : (mask_rdata | bit_sel);
    assign mask_raddr = i_cmd.mask_read ? r_active : r_rd_addr;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= '0;
            r_active_valid <= 1'b0;
            r_ever         <= 1'b0;
            r_scan_ptr     <= '0;
            r_vbits        <= '0;
            r_preempt      <= tss_pkg::PREEMPT_RESET;
            r_left         <= '0;
            r_chk_vld      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_preempt <= i_cfg_data;
            end
            if (i_cmd.demote || i_cmd.park) begin
                r_active_valid <= 1'b0;
            end else if (find_run_hit) begin
                r_active_valid <= 1'b1;
                r_active       <= r_chk_addr;
                r_scan_ptr     <= chk_next;
            end
            if (i_cmd.mark_dispatched) begin
                r_ever <= 1'b1;
            end
            if (find_empty_hit) begin
                r_vbits[r_chk_addr] <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_left    <= LEFT_W'(SLOT_COUNT);
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_chk_vld <= left_nz;
                if (left_nz) begin
                    r_left <= r_left - 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign idx_ext   = IDX_EXT_W'(r_idx);
    assign woken_sat = (r_woken > tss_pkg::WOKEN_MAX) ? 6'd63 : r_woken[5:0];

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_in_data.command;
            r_vec <= i_in_data.vector;
        end
        if (i_cmd.scan_start) begin
            r_rd_addr <= i_cmd.scan_from_ptr ? r_scan_ptr : '0;
        end else if (i_cmd.scan_run && left_nz) begin
            r_rd_addr <= rd_next;
        end
        if (i_cmd.scan_run) begin
            r_chk_addr <= r_rd_addr;
            r_chk_vbit <= r_vbits[r_rd_addr];
        end
        if (i_cmd.init) begin
            r_status <= i_cmd.init_status;
            r_idx    <= r_active;
            r_pre    <= i_cmd.set_pre;
            r_woken  <= '0;
        end else if (find_empty_hit || find_run_hit) begin
            r_status <= tss_pkg::STS_OK;
            r_idx    <= r_chk_addr;
        end else if (wake_hit) begin
            r_woken <= r_woken + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out.status      <= r_status;
            r_out.slot_index  <= idx_ext[4:0];
            r_out.preempted   <= r_pre;
            r_out.woken_count <= woken_sat;
        end
    end

    assign o_stat.cmd             = r_cmd;
    assign o_stat.active_valid    = r_active_valid;
    assign o_stat.ever_dispatched = r_ever;
    assign o_stat.vec_ok          = vec_ok;
    assign o_stat.preempt_hit     = r_active_valid && (r_vec == r_preempt);
    assign o_stat.hit             = find_empty_hit || find_run_hit;
    assign o_stat.scan_done       = !left_nz && !r_chk_vld;
    assign o_stat.out_free        = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> hdl/task_slot_scheduler.sv
// task slot scheduler top level: controller plus datapath
// depends on tss_pkg, tss_ctrl, tss_datapath
//
// usage:
//   request in: i_in_valid / o_in_stall / i_in_data (command, vector); a request
//   is taken on a clock edge with i_in_valid high and o_in_stall low
//   result out: o_out_valid / i_out_stall / o_out_data (status, slot_index,
//   preempted, woken_count), exactly one result per request, held while stalled
//   config: i_cfg_valid / o_cfg_ready / i_cfg_data writes preempt_vector;
//   ready is always high, write only while no request is in flight
// timing:
//   one request at a time; wait, arm with no active task or an out-of-range vector,
//   an ignored interrupt and unknown commands go from decode straight to the result;
//   arm reads and then writes the vector mask of the active slot; create, dispatch and
//   interrupt scan up to SLOT_COUNT slots, one slot per cycle, through the slot state memory;
//   an interrupt after the first dispatch always scans every slot
//   the next request is taken the cycle after the result is loaded; the next request
//   is taken while the last result still waits in the output register, and a stalled
//   result holds back only its completion
// reset:
//   synchronous active-low; all slots empty, no active task, scan pointer 0,
//   preempt_vector 40; slot valid flags clear at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module task_slot_scheduler #(
    parameter int SLOT_COUNT   = tss_pkg::SLOT_COUNT_DEF,
    parameter int VECTOR_COUNT = tss_pkg::VECTOR_COUNT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire tss_pkg::t_in_req          i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output tss_pkg::t_out_req              o_out_data,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [tss_pkg::VEC_W-1:0] i_cfg_data
);

    tss_pkg::t_dp_cmd  dp_cmd;
    tss_pkg::t_dp_stat dp_stat;

    tss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    tss_datapath #(
        .SLOT_COUNT   (SLOT_COUNT),
        .VECTOR_COUNT (VECTOR_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire
